// File: hdl/tmhp_pkg.sv
// Shared types and constants for the MMTP/TLV header parser.
// No dependencies; used by every module of the block.
package tmhp_pkg;

    localparam logic [7:0]  SYNC_BYTE        = 8'h7F;
    localparam logic [7:0]  HDR_IPV6_UDP     = 8'h60;
    localparam logic [7:0]  HDR_NOHDR_A      = 8'h61;
    localparam logic [7:0]  HDR_NOHDR_B      = 8'h20;
    localparam logic [7:0]  HDR_NOHDR_C      = 8'h21;
    // MMTP header start, counted from the first TLV data byte
    localparam logic [5:0]  MMTP_START_IPV6  = 6'd45;   // 3 + 38 + 4
    localparam logic [5:0]  MMTP_START_NOHDR = 6'd3;
    localparam logic [16:0] POS_MAX          = 17'h1FFFF;
    localparam logic [7:0]  CIP_TYPE_RESET   = 8'd3;
    localparam logic [5:0]  PTYPE_MPU        = 6'd0;
    localparam logic [5:0]  PTYPE_SIGNALING  = 6'd2;

    typedef enum logic [2:0] {
        KIND_INVALID   = 3'd0,
        KIND_TLV       = 3'd1,
        KIND_MMTP      = 3'd2,
        KIND_MPU       = 3'd3,
        KIND_SIGNALING = 3'd4
    } kind_t;

    // Everything the back end needs to finish one buffer
    typedef struct packed {
        logic [16:0] last_pos;     // position of the last byte, saturated
        logic [15:0] length;
        logic [7:0]  tlv_type;
        logic        sync_ok;
        logic        is_cip;
        logic [5:0]  mmtp_start;
        logic [7:0]  flags;
        logic [15:0] ext_len;
        logic [15:0] ctx;
        logic [5:0]  ptype;
        logic [15:0] pkt_id;
        logic [31:0] tstamp;
        logic [31:0] seq;
        logic [7:0]  pay0;
        logic [7:0]  pay1;
        logic [3:0]  frag;
        logic [31:0] mpu_seq;
    } snap_t;

endpackage

// File: hdl/tmhp_front.sv
// Front end: takes buffer bytes, tracks position and captures header fields.
// On the last byte it hands a snapshot to the queue. Uses tmhp_pkg.
module tmhp_front import tmhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    input  logic        q_full,
    output logic        q_push,
    output snap_t       q_data
);

    logic [7:0]  cip_type_reg;
    logic [16:0] pos_reg, pos_next, pos_upd;
    logic [15:0] len_reg, len_next, len_upd;
    logic [7:0]  type_reg, type_next, type_upd;
    logic [7:0]  sync_reg, sync_next, sync_upd;
    logic [5:0]  mstart_reg, mstart_next, mstart_upd;
    logic [16:0] pstart_reg, pstart_next, pstart_upd;
    logic [15:0] ext_reg, ext_next, ext_upd;
    logic [7:0]  flag_reg, flag_next, flag_upd;
    logic [15:0] ctx_reg, ctx_next, ctx_upd;
    logic [5:0]  ptype_reg, ptype_next, ptype_upd;
    logic [15:0] pid_reg, pid_next, pid_upd;
    logic [31:0] ts_reg, ts_next, ts_upd;
    logic [31:0] seq_reg, seq_next, seq_upd;
    logic [7:0]  pay0_reg, pay0_next, pay0_upd;
    logic [7:0]  pay1_reg, pay1_next, pay1_upd;
    logic [3:0]  frag_reg, frag_next, frag_upd;
    logic [31:0] mpu_reg, mpu_next, mpu_upd;

    logic        accept;
    logic [16:0] q;
    logic [16:0] rel;
    logic [16:0] d;
    logic        in_pkt;
    logic [16:0] ebase;
    logic [1:0]  bsel;
    logic [1:0]  dsel;
    logic [16:0] ext_hi_rel;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && s_last_byte;

    always_comb begin
        q          = pos_reg - 17'd4;
        in_pkt     = (pos_reg >= 17'd4) && (q < {1'b0, len_reg});
        rel        = q - {11'd0, mstart_reg};
        d          = q - pstart_reg;
        bsel       = 2'd3 - rel[1:0];
        dsel       = 2'd3 - d[1:0];
        ebase      = {11'd0, mstart_reg} + (flag_reg[5] ? 17'd16 : 17'd12);
        ext_hi_rel = flag_reg[5] ? 17'd18 : 17'd14;

        pos_upd    = (pos_reg < POS_MAX) ? pos_reg + 17'd1 : pos_reg;
        len_upd    = len_reg;
        type_upd   = type_reg;
        sync_upd   = sync_reg;
        mstart_upd = mstart_reg;
        pstart_upd = pstart_reg;
        ext_upd    = ext_reg;
        flag_upd   = flag_reg;
        ctx_upd    = ctx_reg;
        ptype_upd  = ptype_reg;
        pid_upd    = pid_reg;
        ts_upd     = ts_reg;
        seq_upd    = seq_reg;
        pay0_upd   = pay0_reg;
        pay1_upd   = pay1_reg;
        frag_upd   = frag_reg;
        mpu_upd    = mpu_reg;

        if (pos_reg == 17'd0) begin
            sync_upd = s_byte_value;
        end else if (pos_reg == 17'd1) begin
            type_upd = s_byte_value;
        end else if (pos_reg == 17'd2) begin
            len_upd = {s_byte_value, 8'h00};
        end else if (pos_reg == 17'd3) begin
            len_upd = {len_reg[15:8], s_byte_value};
        end else if (in_pkt) begin
            if (q == 17'd0) begin
                ctx_upd[15:8] = s_byte_value;
            end else if (q == 17'd1) begin
                ctx_upd[7:0] = s_byte_value;
            end else if (q == 17'd2) begin
                case (s_byte_value) inside
                    HDR_IPV6_UDP:                          mstart_upd = MMTP_START_IPV6;
                    HDR_NOHDR_A, HDR_NOHDR_B, HDR_NOHDR_C: mstart_upd = MMTP_START_NOHDR;
                    default:                               mstart_upd = 6'd0;
                endcase
            end else if (mstart_reg != 6'd0 && q >= {11'd0, mstart_reg}) begin
                if (rel == 17'd0) begin
                    flag_upd = s_byte_value;
                    if (!s_byte_value[1]) begin
                        pstart_upd = {11'd0, mstart_reg}
                                     + (s_byte_value[5] ? 17'd16 : 17'd12);
                    end
                end else if (rel == 17'd1) begin
                    ptype_upd = s_byte_value[5:0];
                end else if (rel == 17'd2) begin
                    pid_upd[15:8] = s_byte_value;
                end else if (rel == 17'd3) begin
                    pid_upd[7:0] = s_byte_value;
                end else if (rel < 17'd8) begin
                    ts_upd[{bsel, 3'b000} +: 8] = s_byte_value;
                end else if (rel < 17'd12) begin
                    seq_upd[{bsel, 3'b000} +: 8] = s_byte_value;
                end else begin
                    if (flag_reg[1]) begin
                        if (rel == ext_hi_rel) begin
                            ext_upd = {s_byte_value, 8'h00};
                        end else if (rel == ext_hi_rel + 17'd1) begin
                            ext_upd    = {ext_reg[15:8], s_byte_value};
                            pstart_upd = ebase + 17'd4 + {1'b0, ext_reg[15:8], s_byte_value};
                        end
                    end
                    // old start is safe: a start set on this byte lies past it
                    if (pstart_reg != 17'd0 && q >= pstart_reg) begin
                        if (d == 17'd0) begin
                            pay0_upd = s_byte_value;
                        end else if (d == 17'd1) begin
                            pay1_upd = s_byte_value;
                        end else if (d == 17'd2) begin
                            frag_upd = s_byte_value[7:4];
                        end else if (d >= 17'd4 && d < 17'd8) begin
                            mpu_upd[{dsel, 3'b000} +: 8] = s_byte_value;
                        end
                    end
                end
            end
        end
    end

    // snapshot of the state as it stands after the last byte
    always_comb begin
        q_data.last_pos   = pos_reg;
        q_data.length     = len_upd;
        q_data.tlv_type   = type_upd;
        q_data.sync_ok    = (sync_upd == SYNC_BYTE);
        q_data.is_cip     = (type_upd == cip_type_reg);
        q_data.mmtp_start = mstart_upd;
        q_data.flags      = flag_upd;
        q_data.ext_len    = ext_upd;
        q_data.ctx        = ctx_upd;
        q_data.ptype      = ptype_upd;
        q_data.pkt_id     = pid_upd;
        q_data.tstamp     = ts_upd;
        q_data.seq        = seq_upd;
        q_data.pay0       = pay0_upd;
        q_data.pay1       = pay1_upd;
        q_data.frag       = frag_upd;
        q_data.mpu_seq    = mpu_upd;
    end

    always_comb begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        type_next   = type_reg;
        sync_next   = sync_reg;
        mstart_next = mstart_reg;
        pstart_next = pstart_reg;
        ext_next    = ext_reg;
        flag_next   = flag_reg;
        ctx_next    = ctx_reg;
        ptype_next  = ptype_reg;
        pid_next    = pid_reg;
        ts_next     = ts_reg;
        seq_next    = seq_reg;
        pay0_next   = pay0_reg;
        pay1_next   = pay1_reg;
        frag_next   = frag_reg;
        mpu_next    = mpu_reg;
        if (accept && s_last_byte) begin
            pos_next    = '0;
            len_next    = '0;
            type_next   = '0;
            sync_next   = '0;
            mstart_next = '0;
            pstart_next = '0;
            ext_next    = '0;
            flag_next   = '0;
            ctx_next    = '0;
            ptype_next  = '0;
            pid_next    = '0;
            ts_next     = '0;
            seq_next    = '0;
            pay0_next   = '0;
            pay1_next   = '0;
            frag_next   = '0;
            mpu_next    = '0;
        end else if (accept) begin
            pos_next    = pos_upd;
            len_next    = len_upd;
            type_next   = type_upd;
            sync_next   = sync_upd;
            mstart_next = mstart_upd;
            pstart_next = pstart_upd;
            ext_next    = ext_upd;
            flag_next   = flag_upd;
            ctx_next    = ctx_upd;
            ptype_next  = ptype_upd;
            pid_next    = pid_upd;
            ts_next     = ts_upd;
            seq_next    = seq_upd;
            pay0_next   = pay0_upd;
            pay1_next   = pay1_upd;
            frag_next   = frag_upd;
            mpu_next    = mpu_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cip_type_reg <= CIP_TYPE_RESET;
            pos_reg      <= '0;
            len_reg      <= '0;
            type_reg     <= '0;
            sync_reg     <= '0;
            mstart_reg   <= '0;
            pstart_reg   <= '0;
            ext_reg      <= '0;
            flag_reg     <= '0;
            ctx_reg      <= '0;
            ptype_reg    <= '0;
            pid_reg      <= '0;
            ts_reg       <= '0;
            seq_reg      <= '0;
            pay0_reg     <= '0;
            pay1_reg     <= '0;
            frag_reg     <= '0;
            mpu_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                cip_type_reg <= cfg_wr_data;
            end
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            sync_reg   <= sync_next;
            mstart_reg <= mstart_next;
            pstart_reg <= pstart_next;
            ext_reg    <= ext_next;
            flag_reg   <= flag_next;
            ctx_reg    <= ctx_next;
            ptype_reg  <= ptype_next;
            pid_reg    <= pid_next;
            ts_reg     <= ts_next;
            seq_reg    <= seq_next;
            pay0_reg   <= pay0_next;
            pay1_reg   <= pay1_next;
            frag_reg   <= frag_next;
            mpu_reg    <= mpu_next;
        end
    end

endmodule

// File: hdl/tmhp_queue.sv
// Two-entry queue of buffer snapshots between front and back end.
// Uses tmhp_pkg for the snapshot type.
module tmhp_queue import tmhp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  snap_t push_data,
    output logic  full,
    output logic  not_empty,
    input  logic  pop,
    output snap_t head
);

    snap_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/tmhp_back.sv
// Back end: runs the length checks on one snapshot and registers the result.
// Uses tmhp_pkg; fed by tmhp_queue.
module tmhp_back import tmhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  snap_t       q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [16:0] m_packet_size,
    output logic [7:0]  m_tlv_type,
    output logic [11:0] m_context_id,
    output logic        m_rap_flag,
    output logic [5:0]  m_payload_type,
    output logic [15:0] m_packet_id,
    output logic [31:0] m_delivery_timestamp,
    output logic [31:0] m_packet_sequence,
    output logic [31:0] m_mpu_sequence,
    output logic [3:0]  m_payload_flags,
    output logic [16:0] m_signaling_offset
);

    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [16:0] size_reg, size_next;
    logic [7:0]  type_reg, type_next;
    logic [11:0] ctx_reg, ctx_next;
    logic        rap_reg, rap_next;
    logic [5:0]  ptype_reg, ptype_next;
    logic [15:0] pid_reg, pid_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] mpu_reg, mpu_next;
    logic [3:0]  pflags_reg, pflags_next;
    logic [16:0] sigoff_reg, sigoff_next;

    logic [17:0] len18, last18, m18, pos_a, pos_b, pos_c, pos, plen18;
    logic        buf_ok, hdr_ok, cnt_ok, ext_hdr_ok, ext_ok;
    logic        load;

    assign load  = !valid_reg || m_ready;
    assign q_pop = q_valid && load;

    always_comb begin
        len18      = {2'b00, q_head.length};
        last18     = {1'b0, q_head.last_pos};
        m18        = {12'd0, q_head.mmtp_start};
        plen18     = {2'b00, q_head.pay0, q_head.pay1};
        buf_ok     = (last18 >= 18'd3) && q_head.sync_ok && (len18 + 18'd3 <= last18);
        hdr_ok     = (q_head.mmtp_start != 6'd0) && (len18 >= m18 + 18'd12);
        pos_a      = m18 + (q_head.flags[5] ? 18'd16 : 18'd12);
        cnt_ok     = !q_head.flags[5] || (len18 >= pos_a);
        pos_b      = pos_a + 18'd4;
        ext_hdr_ok = !q_head.flags[1] || (len18 >= pos_b);
        pos_c      = pos_b + {2'b00, q_head.ext_len};
        ext_ok     = !q_head.flags[1] || (len18 >= pos_c);
        pos        = q_head.flags[1] ? pos_c : pos_a;
    end

    always_comb begin
        kind_next   = KIND_INVALID;
        size_next   = '0;
        type_next   = '0;
        ctx_next    = '0;
        rap_next    = 1'b0;
        ptype_next  = '0;
        pid_next    = '0;
        ts_next     = '0;
        seq_next    = '0;
        mpu_next    = '0;
        pflags_next = '0;
        sigoff_next = '0;
        if (buf_ok) begin
            kind_next = KIND_TLV;
            size_next = {1'b0, q_head.length} + 17'd4;
            type_next = q_head.tlv_type;
            if (q_head.is_cip && q_head.length >= 16'd3) begin
                ctx_next = q_head.ctx[15:4];
                if (hdr_ok) begin
                    rap_next   = q_head.flags[0];
                    ptype_next = q_head.ptype;
                    pid_next   = q_head.pkt_id;
                    ts_next    = q_head.tstamp;
                    seq_next   = q_head.seq;
                    if (cnt_ok && ext_hdr_ok && ext_ok) begin
                        kind_next = KIND_MMTP;
                        if (q_head.ptype == PTYPE_MPU) begin
                            if (len18 >= pos + 18'd8 && plen18 + pos + 18'd2 == len18) begin
                                kind_next   = KIND_MPU;
                                mpu_next    = q_head.mpu_seq;
                                pflags_next = q_head.frag;
                            end
                        end else if (q_head.ptype == PTYPE_SIGNALING) begin
                            if (len18 >= pos + 18'd2) begin
                                kind_next   = KIND_SIGNALING;
                                pflags_next = {q_head.pay0[7:6], q_head.pay0[1],
                                               q_head.pay0[0]};
                                sigoff_next = pos[16:0] + 17'd6;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= kind_next;
            size_reg   <= size_next;
            type_reg   <= type_next;
            ctx_reg    <= ctx_next;
            rap_reg    <= rap_next;
            ptype_reg  <= ptype_next;
            pid_reg    <= pid_next;
            ts_reg     <= ts_next;
            seq_reg    <= seq_next;
            mpu_reg    <= mpu_next;
            pflags_reg <= pflags_next;
            sigoff_reg <= sigoff_next;
        end
    end

    assign m_valid              = valid_reg;
    assign m_kind               = kind_reg;
    assign m_packet_size        = size_reg;
    assign m_tlv_type           = type_reg;
    assign m_context_id         = ctx_reg;
    assign m_rap_flag           = rap_reg;
    assign m_payload_type       = ptype_reg;
    assign m_packet_id          = pid_reg;
    assign m_delivery_timestamp = ts_reg;
    assign m_packet_sequence    = seq_reg;
    assign m_mpu_sequence       = mpu_reg;
    assign m_payload_flags      = pflags_reg;
    assign m_signaling_offset   = sigoff_reg;

endmodule

// File: hdl/tlv_mmtp_header_parse.sv
// Top level of the MMTP/TLV header parser.
// Instantiates tmhp_front, tmhp_queue and tmhp_back; uses tmhp_pkg.
//
// Usage:
//   Input channel (s_): one buffer byte per item, s_last_byte set on the
//   buffer's final byte. A byte is taken whenever s_ready is high; the parser keeps
//   position, TLV length and captured header fields as bytes stream by.
//   Result channel (m_): one item per buffer, produced from its last byte.
//   Result path: the last byte's snapshot is written to the queue, then the
//   check stage's output register takes it and drives m_valid.
//   Throughput: one byte per cycle while s_ready is high, including back-to-back
//   one-byte buffers; the front end and the check stage each run at one per cycle.
//   When m_ready is low, up to two finished buffers wait in the queue and
//   one in the output register; s_ready drops only when the queue is full.
//   Reset (aresetn low, synchronous): parse state and queue are cleared,
//   no result is pending, compressed_ip_type returns to 3.
//   cfg_wr_en/cfg_wr_data write compressed_ip_type; write only while idle.
module tlv_mmtp_header_parse import tmhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [16:0] m_packet_size,
    output logic [7:0]  m_tlv_type,
    output logic [11:0] m_context_id,
    output logic        m_rap_flag,
    output logic [5:0]  m_payload_type,
    output logic [15:0] m_packet_id,
    output logic [31:0] m_delivery_timestamp,
    output logic [31:0] m_packet_sequence,
    output logic [31:0] m_mpu_sequence,
    output logic [3:0]  m_payload_flags,
    output logic [16:0] m_signaling_offset
);

    snap_t push_data;
    snap_t head;
    logic  push, full, not_empty, pop;

    tmhp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_value(s_byte_value),
        .s_last_byte (s_last_byte),
        .q_full      (full),
        .q_push      (push),
        .q_data      (push_data)
    );

    tmhp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .head      (head)
    );

    tmhp_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (not_empty),
        .q_head              (head),
        .q_pop               (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_packet_size       (m_packet_size),
        .m_tlv_type          (m_tlv_type),
        .m_context_id        (m_context_id),
        .m_rap_flag          (m_rap_flag),
        .m_payload_type      (m_payload_type),
        .m_packet_id         (m_packet_id),
        .m_delivery_timestamp(m_delivery_timestamp),
        .m_packet_sequence   (m_packet_sequence),
        .m_mpu_sequence      (m_mpu_sequence),
        .m_payload_flags     (m_payload_flags),
        .m_signaling_offset  (m_signaling_offset)
    );

endmodule

// File: tb/sv/tmhp_result_monitor.sv
`timescale 1ns / 1ps
// Result monitor for the MMTP/TLV header parser: watches the byte, config and result channels.
// It keeps its own parser model and compares each result item with it; uses tmhp_pkg.
module tmhp_result_monitor import tmhp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [16:0] m_packet_size,
    input  logic [7:0]  m_tlv_type,
    input  logic [11:0] m_context_id,
    input  logic        m_rap_flag,
    input  logic [5:0]  m_payload_type,
    input  logic [15:0] m_packet_id,
    input  logic [31:0] m_delivery_timestamp,
    input  logic [31:0] m_packet_sequence,
    input  logic [31:0] m_mpu_sequence,
    input  logic [3:0]  m_payload_flags,
    input  logic [16:0] m_signaling_offset,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        kind_t       kind;
        logic [16:0] packet_size;
        logic [7:0]  tlv_type;
        logic [11:0] context_id;
        logic        rap_flag;
        logic [5:0]  payload_type;
        logic [15:0] packet_id;
        logic [31:0] delivery_timestamp;
        logic [31:0] packet_sequence;
        logic [31:0] mpu_sequence;
        logic [3:0]  payload_flags;
        logic [16:0] signaling_offset;
    } header_result_t;

    header_result_t expected_headers [$];

    logic [7:0]  cip_type;
    logic [16:0] rx_pos;
    logic [15:0] tlv_len_f;
    logic [7:0]  tlv_type_f;
    logic [7:0]  hdr_type_f;
    int unsigned mmtp_at;     // 0 while no MMTP header is known
    int unsigned pay_at;      // 0 while the payload start is unknown
    logic [15:0] ext_len_f;
    logic [7:0]  mmtp_flags;
    logic [63:0] cap [3];
    int          results_checked = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, results_checked, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    task automatic clear_parse();
        rx_pos = '0;
        tlv_len_f = '0;
        tlv_type_f = '0;
        hdr_type_f = '0;
        mmtp_at = 0;
        pay_at = 0;
        ext_len_f = '0;
        mmtp_flags = '0;
        cap[0] = '0;
        cap[1] = '0;
        cap[2] = '0;
    endtask

    // first byte after the fixed header and the optional packet counter
    function automatic int unsigned ext_base();
        return mmtp_at + 12 + (mmtp_flags[5] ? 4 : 0);
    endfunction

    // q counts from the first TLV data byte
    task automatic capture_byte(input int unsigned q, input logic [7:0] v);
        int unsigned m;
        int unsigned e;
        int unsigned d;
        m = mmtp_at;
        if (q == 0) cap[0][15:8] = v;
        else if (q == 1) cap[0][7:0] = v;
        else if (q == 2) begin
            hdr_type_f = v;
            if (v == HDR_IPV6_UDP) mmtp_at = MMTP_START_IPV6;
            else if (v == HDR_NOHDR_A || v == HDR_NOHDR_B || v == HDR_NOHDR_C)
                mmtp_at = MMTP_START_NOHDR;
            else mmtp_at = 0;
            return;
        end
        if (m == 0 || q < m) return;
        if (q == m) begin
            mmtp_flags = v;
            if (!v[1]) pay_at = ext_base();
            return;
        end
        if (q == m + 1) begin cap[0][23:16] = v; return; end
        if (q == m + 2) begin cap[0][39:32] = v; return; end
        if (q == m + 3) begin cap[0][31:24] = v; return; end
        if (q >= m + 4 && q < m + 8) begin
            cap[1][8 * (m + 7 - q) +: 8] = v;
            return;
        end
        if (q >= m + 8 && q < m + 12) begin
            cap[1][32 + 8 * (m + 11 - q) +: 8] = v;
            return;
        end
        if (mmtp_flags[1]) begin
            e = ext_base();
            if (q == e + 2) ext_len_f = {v, 8'h00};
            else if (q == e + 3) begin
                ext_len_f[7:0] = v;
                pay_at = e + 4 + ext_len_f;
            end
        end
        if (pay_at != 0 && q >= pay_at) begin
            d = q - pay_at;
            if (d == 0) cap[0][55:48] = v;
            else if (d == 1) cap[0][47:40] = v;
            else if (d == 2) cap[0][63:56] = v;
            else if (d >= 4 && d < 8) cap[2][8 * (7 - d) +: 8] = v;
        end
    endtask

    // p is the position of the buffer's last byte
    function automatic header_result_t summarize(input int unsigned p);
        header_result_t r;
        int unsigned len;
        int unsigned pos;
        int unsigned plen;
        logic [7:0] sb;
        r = '0;
        len = tlv_len_f;
        if (p + 1 < 4 || cap[2][39:32] != SYNC_BYTE || 4 + len > p + 1) return r;
        r.kind = KIND_TLV;
        r.packet_size = 17'(4 + len);
        r.tlv_type = tlv_type_f;
        if (tlv_type_f != cip_type || len < 3) return r;
        r.context_id = cap[0][15:4];
        if (mmtp_at == 0 || len < mmtp_at + 12) return r;
        // fixed header is reported even if the options below turn out truncated
        r.rap_flag = mmtp_flags[0];
        r.payload_type = cap[0][21:16];
        r.packet_id = cap[0][39:24];
        r.delivery_timestamp = cap[1][31:0];
        r.packet_sequence = cap[1][63:32];
        pos = mmtp_at + 12;
        if (mmtp_flags[5]) begin
            if (len < pos + 4) return r;
            pos += 4;
        end
        if (mmtp_flags[1]) begin
            if (len < pos + 4) return r;
            pos += 4;
            if (len < pos + ext_len_f) return r;
            pos += ext_len_f;
        end
        r.kind = KIND_MMTP;
        if (r.payload_type == PTYPE_MPU) begin
            plen = cap[0][55:40];
            if (len >= pos + 8 && plen == len - pos - 2) begin
                r.kind = KIND_MPU;
                r.mpu_sequence = cap[2][31:0];
                r.payload_flags = cap[0][63:60];
            end
        end else if (r.payload_type == PTYPE_SIGNALING) begin
            if (len >= pos + 2) begin
                sb = cap[0][55:48];
                r.kind = KIND_SIGNALING;
                r.payload_flags = {sb[7:6], sb[1], sb[0]};
                r.signaling_offset = 17'(4 + pos + 2);
            end
        end
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] v, input logic last);
        int unsigned p;
        p = rx_pos;
        if (p == 0) cap[2][39:32] = v;
        else if (p == 1) tlv_type_f = v;
        else if (p == 2) tlv_len_f = {v, 8'h00};
        else if (p == 3) tlv_len_f[7:0] = v;
        else if (p - 4 < tlv_len_f) capture_byte(p - 4, v);
        if (rx_pos < POS_MAX) rx_pos = rx_pos + 1'b1;
        if (last) begin
            expected_headers.insert(expected_headers.size(), summarize(p));
            clear_parse();
        end
    endtask

    always @(posedge aclk) begin : watch
        header_result_t want;
        if (!aresetn) begin
            cip_type = CIP_TYPE_RESET;
            clear_parse();
            expected_headers.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_headers.size() == 0) begin
                    report_mismatch("result item with nothing predicted");
                end else begin
                    want = expected_headers.pop_front();
                    check_field("kind", m_kind, want.kind);
                    check_field("packet_size", m_packet_size, want.packet_size);
                    check_field("tlv_type", m_tlv_type, want.tlv_type);
                    check_field("context_id", m_context_id, want.context_id);
                    check_field("rap_flag", m_rap_flag, want.rap_flag);
                    check_field("payload_type", m_payload_type, want.payload_type);
                    check_field("packet_id", m_packet_id, want.packet_id);
                    check_field("delivery_timestamp", m_delivery_timestamp,
                                want.delivery_timestamp);
                    check_field("packet_sequence", m_packet_sequence, want.packet_sequence);
                    check_field("mpu_sequence", m_mpu_sequence, want.mpu_sequence);
                    check_field("payload_flags", m_payload_flags, want.payload_flags);
                    check_field("signaling_offset", m_signaling_offset,
                                want.signaling_offset);
                end
                results_checked++;
            end
            if (cfg_wr_en) cip_type = cfg_wr_data;
            if (s_valid && s_ready) predict_byte(s_byte_value, s_last_byte);
        end
        pending_count = expected_headers.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the MMTP/TLV header parser testbench: clock, reset, byte stimulus and verdict.
// Depends on tlv_mmtp_header_parse, tmhp_result_monitor and tmhp_pkg.
module testbench import tmhp_pkg::*;;

    localparam int STALL_LIMIT = 2000;
    localparam int SEG_BYTES   = 165;
    localparam int SEG_BUFS    = 4;
    localparam int BIG_BUF     = 131080;   // long enough to saturate the position

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [16:0] m_packet_size;
    logic [7:0]  m_tlv_type;
    logic [11:0] m_context_id;
    logic        m_rap_flag;
    logic [5:0]  m_payload_type;
    logic [15:0] m_packet_id;
    logic [31:0] m_delivery_timestamp;
    logic [31:0] m_packet_sequence;
    logic [31:0] m_mpu_sequence;
    logic [3:0]  m_payload_flags;
    logic [16:0] m_signaling_offset;

    int fail_count;
    int pending_count;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    logic [7:0] cip_now = CIP_TYPE_RESET;
    logic [7:0] buf_q [$];
    int total_bytes = 0;
    int total_bufs = 0;

    tlv_mmtp_header_parse u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_byte_value         (s_byte_value),
        .s_last_byte          (s_last_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_kind               (m_kind),
        .m_packet_size        (m_packet_size),
        .m_tlv_type           (m_tlv_type),
        .m_context_id         (m_context_id),
        .m_rap_flag           (m_rap_flag),
        .m_payload_type       (m_payload_type),
        .m_packet_id          (m_packet_id),
        .m_delivery_timestamp (m_delivery_timestamp),
        .m_packet_sequence    (m_packet_sequence),
        .m_mpu_sequence       (m_mpu_sequence),
        .m_payload_flags      (m_payload_flags),
        .m_signaling_offset   (m_signaling_offset)
    );

    tmhp_result_monitor u_monitor (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_byte_value         (s_byte_value),
        .s_last_byte          (s_last_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_kind               (m_kind),
        .m_packet_size        (m_packet_size),
        .m_tlv_type           (m_tlv_type),
        .m_context_id         (m_context_id),
        .m_rap_flag           (m_rap_flag),
        .m_payload_type       (m_payload_type),
        .m_packet_id          (m_packet_id),
        .m_delivery_timestamp (m_delivery_timestamp),
        .m_packet_sequence    (m_packet_sequence),
        .m_mpu_sequence       (m_mpu_sequence),
        .m_payload_flags      (m_payload_flags),
        .m_signaling_offset   (m_signaling_offset),
        .fail_count           (fail_count),
        .pending_count        (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ends the run when neither channel moves an item for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("stalled for %0d cycles with %0d results outstanding",
                 STALL_LIMIT, pending_count);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_byte(input logic [7:0] v, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_value <= v;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        total_bytes++;
    endtask

    task automatic send_buffer();
        int i;
        for (i = 0; i < buf_q.size(); i++)
            send_byte(buf_q[i], i == buf_q.size() - 1);
        total_bufs++;
    endtask

    // config is only touched once the parser has drained
    task automatic write_cip(input logic [7:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        cip_now = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One buffer holding a mostly well-formed TLV/MMTP packet. Length, sync, type,
    // header type and tail are bent now and then to reach the short and invalid paths.
    task automatic make_buffer(input bit big);
        logic [7:0]  body [$];
        logic [7:0]  flags;
        logic [7:0]  hdr;
        logic [7:0]  b;
        logic [5:0]  ptype;
        logic [15:0] plen;
        logic [15:0] ext_n;
        logic [15:0] len16;
        int          sel;
        int          pay_at;
        int          tlv_len;
        int          extra;
        int          i;
        buf_q.delete();
        body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), 8'($urandom));
        sel = $urandom_range(9);
        hdr = 8'($urandom);
        if (big) hdr = HDR_NOHDR_A;
        else if (sel < 3) hdr = HDR_IPV6_UDP;
        else if (sel < 5) hdr = HDR_NOHDR_A;
        else if (sel < 7) hdr = HDR_NOHDR_B;
        else if (sel < 9) hdr = HDR_NOHDR_C;
        body.insert(body.size(), hdr);
        if (hdr == HDR_IPV6_UDP) repeat (42) body.insert(body.size(), 8'($urandom));
        flags = 8'($urandom);
        body.insert(body.size(), flags);
        sel = $urandom_range(9);
        ptype = 6'($urandom);
        if (big || sel < 4) ptype = PTYPE_MPU;
        else if (sel < 8) ptype = PTYPE_SIGNALING;
        b = 8'($urandom);
        b[5:0] = ptype;
        body.insert(body.size(), b);
        // packet id, timestamp, sequence
        repeat (10) body.insert(body.size(), 8'($urandom));
        if (flags[5]) repeat (4) body.insert(body.size(), 8'($urandom));
        if (flags[1]) begin
            ext_n = 16'($urandom_range(6));
            repeat (2) body.insert(body.size(), 8'($urandom));
            if (!big && $urandom_range(9) == 0) begin
                // claims an extension far longer than the packet
                body.insert(body.size(), 8'($urandom));
                body.insert(body.size(), 8'($urandom));
            end else begin
                body.insert(body.size(), ext_n[15:8]);
                body.insert(body.size(), ext_n[7:0]);
                repeat (ext_n) body.insert(body.size(), 8'($urandom));
            end
        end
        pay_at = body.size();
        repeat (8 + $urandom_range(6)) body.insert(body.size(), 8'($urandom));
        if (big) while (body.size() < 65535) body.insert(body.size(), 8'($urandom));
        tlv_len = body.size();
        sel = $urandom_range(9);
        if (!big) begin
            if (sel == 7 || sel == 8) tlv_len = $urandom_range(body.size());
            else if (sel == 9) tlv_len = body.size() - $urandom_range(1, 4);
        end
        if (ptype == PTYPE_MPU) begin
            plen = 16'(tlv_len - pay_at - 2);
            if ($urandom_range(7) == 0) plen = plen + 1'b1;
            body[pay_at] = plen[15:8];
            body[pay_at + 1] = plen[7:0];
        end
        b = SYNC_BYTE;
        if (!big && $urandom_range(19) == 0) b = 8'($urandom);
        buf_q.insert(buf_q.size(), b);
        b = cip_now;
        if (!big && $urandom_range(6) == 0) b = 8'($urandom);
        buf_q.insert(buf_q.size(), b);
        len16 = 16'(tlv_len);
        buf_q.insert(buf_q.size(), len16[15:8]);
        buf_q.insert(buf_q.size(), len16[7:0]);
        for (i = 0; i < tlv_len; i++) buf_q.insert(buf_q.size(), body[i]);
        sel = $urandom_range(9);
        if (big) begin
            while (buf_q.size() < BIG_BUF) buf_q.insert(buf_q.size(), 8'($urandom));
        end else if (sel == 6 || sel == 7) begin
            repeat ($urandom_range(1, 5)) buf_q.insert(buf_q.size(), 8'($urandom));
        end else if (sel >= 8) begin
            // buffer ends before the packet does
            extra = $urandom_range(1, 3);
            while (extra > 0 && buf_q.size() > 1) begin
                void'(buf_q.pop_back());
                extra--;
            end
        end
    endtask

    initial begin : stimulus
        logic [8:0] directed_items [24];
        logic [7:0] cfg_plan [6];
        int seg;
        int seg_bytes;
        int seg_bufs;
        int n;
        int i;
        // bit 8 marks the buffer's last byte
        directed_items = '{
            9'h100,                                         // lone byte
            9'h07F, 9'h0FF, 9'h1FF,                         // under four bytes
            9'h07F, 9'h000, 9'h000, 9'h100,                 // empty TLV
            9'h0FF, 9'h003, 9'h000, 9'h100,                 // bad sync
            9'h07F, 9'h003, 9'h000, 9'h003, 9'h0FF, 9'h0F0, 9'h161,
            9'h07F, 9'h003, 9'h000, 9'h005, 9'h100          // packet past buffer end
        };
        cfg_plan = '{8'h00, 8'hFF, 8'h00, CIP_TYPE_RESET, 8'h00, 8'hFF};
        cfg_plan[2] = 8'($urandom);
        cfg_plan[4] = 8'($urandom);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 25;
        sink_idle_pct = 53;
        for (i = 0; i < 24; i++) begin
            send_byte(directed_items[i][7:0], directed_items[i][8]);
            if (directed_items[i][8]) total_bufs++;
        end

        for (seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin src_idle_pct = 25; sink_idle_pct = 53; end
                1: begin src_idle_pct = 53; sink_idle_pct = 25; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            write_cip(cfg_plan[seg]);
            seg_bytes = 0;
            seg_bufs = 0;
            while (seg_bytes < SEG_BYTES || seg_bufs < SEG_BUFS) begin
                if ($urandom_range(99) < 15) begin
                    buf_q.delete();
                    n = $urandom_range(1, 6);
                    repeat (n) buf_q.insert(buf_q.size(), 8'($urandom));
                    if ($urandom_range(1)) buf_q[0] = SYNC_BYTE;
                end else begin
                    make_buffer(1'b0);
                end
                seg_bytes += buf_q.size();
                send_buffer();
                seg_bufs++;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d bytes in %0d buffers, well-formed, truncated and malformed",
                 total_bytes, total_bufs);
        $display("over six compressed-IP type settings and three flow-control mixes");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: tlv_mmtp_header_parse.f
hdl/tmhp_pkg.sv
hdl/tmhp_front.sv
hdl/tmhp_queue.sv
hdl/tmhp_back.sv
hdl/tlv_mmtp_header_parse.sv
tb/sv/tmhp_result_monitor.sv
tb/sv/testbench.sv
